[design/lpg_pkg.sv]
// Shared types and constants for the line pixel generator.
// No dependencies; every other design file imports this package.
`default_nettype none

package lpg_pkg;

    // Coordinate span and derived widths.
    localparam int COORD_SPAN = 512;
    localparam int COORD_W    = $clog2(COORD_SPAN);
    localparam int DELTA_W    = COORD_W + 1;
    localparam int ERR_W      = COORD_W + 3;

    // Fixed field widths.
    localparam int STRIDE_W   = 10;
    localparam int ADDR_W     = 18;
    localparam int COLOR_W    = 16;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(512);

    // Item function codes.
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    // One input word as held in the input register.
    typedef struct packed {
        t_func               func;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  end_x;
        logic [COORD_W-1:0]  end_y;
        logic [COLOR_W-1:0]  color;
    } t_item;

    // One pixel before its address is formed.
    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } t_pixel;

    // Status of the stepper stage.
    typedef struct packed {
        logic busy;
        logic accept;
    } t_step_status;

endpackage

`default_nettype wire

[design/lpg_stepper.sv]
// Bresenham stepper: holds the line state and emits one pixel per start word and per step word while a line is active.
// Depends on lpg_pkg for the item and pixel types.
`default_nettype none

module lpg_stepper (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire  lpg_pkg::t_item   i_item,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output lpg_pkg::t_pixel        o_pixel,
    output lpg_pkg::t_step_status  o_status
);
    import lpg_pkg::*;

    // Control state.
    logic r_valid, n_valid;
    logic r_busy, n_busy;

    // Line state.
    logic [COORD_W-1:0] r_cur_col, n_cur_col;
    logic [COORD_W-1:0] r_cur_row, n_cur_row;
    logic [COORD_W-1:0] r_goal_col, n_goal_col;
    logic [COORD_W-1:0] r_goal_row, n_goal_row;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic [DELTA_W-1:0] r_twice_dx, n_twice_dx;
    logic [DELTA_W-1:0] r_twice_dy, n_twice_dy;
    logic r_col_down, n_col_down;
    logic r_row_down, n_row_down;
    logic r_col_major, n_col_major;
    logic [COLOR_W-1:0] r_color, n_color;
    t_pixel r_pixel, n_pixel;

    logic accept;
    logic has_result;

    // Start decode.
    logic               st_col_down;
    logic               st_row_down;
    logic [COORD_W-1:0] st_dx;
    logic [COORD_W-1:0] st_dy;
    logic [DELTA_W-1:0] st_tdx;
    logic [DELTA_W-1:0] st_tdy;
    logic               st_col_major;
    logic signed [ERR_W-1:0] st_err;

    // Step decode.
    logic               err_nonneg;
    logic signed [ERR_W-1:0] tdx_ext;
    logic signed [ERR_W-1:0] tdy_ext;
    logic [COORD_W-1:0] col_moved;
    logic [COORD_W-1:0] row_moved;

    assign o_in_ready = !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign has_result = (i_item.func == FUNC_START) || r_busy;

    // Deltas, directions and initial error for a new line.
    always_comb begin
        st_col_down  = i_item.end_x < i_item.start_x;
        st_row_down  = i_item.end_y < i_item.start_y;
        st_dx        = st_col_down ? i_item.start_x - i_item.end_x
                                   : i_item.end_x - i_item.start_x;
        st_dy        = st_row_down ? i_item.start_y - i_item.end_y
                                   : i_item.end_y - i_item.start_y;
        st_tdx       = {st_dx, 1'b0};
        st_tdy       = {st_dy, 1'b0};
        st_col_major = st_tdx > st_tdy;
        if (st_col_major) begin
            st_err = $signed({2'b00, st_tdy}) - $signed({3'b000, st_dx});
        end else begin
            st_err = $signed({2'b00, st_tdx}) - $signed({3'b000, st_dy});
        end
    end

    // One step along the major axis, with a minor step when the error allows.
    assign err_nonneg = !r_err[ERR_W-1];
    assign tdx_ext    = $signed({2'b00, r_twice_dx});
    assign tdy_ext    = $signed({2'b00, r_twice_dy});
    assign col_moved  = r_col_down ? r_cur_col - 1'b1 : r_cur_col + 1'b1;
    assign row_moved  = r_row_down ? r_cur_row - 1'b1 : r_cur_row + 1'b1;

    always_comb begin
        n_valid     = r_valid;
        n_busy      = r_busy;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_goal_col  = r_goal_col;
        n_goal_row  = r_goal_row;
        n_err       = r_err;
        n_twice_dx  = r_twice_dx;
        n_twice_dy  = r_twice_dy;
        n_col_down  = r_col_down;
        n_row_down  = r_row_down;
        n_col_major = r_col_major;
        n_color     = r_color;
        n_pixel     = r_pixel;

        if (i_out_ready) begin
            n_valid = 1'b0;
        end

        if (accept) begin
            n_valid = has_result;
            if (i_item.func == FUNC_START) begin
                n_cur_col     = i_item.start_x;
                n_cur_row     = i_item.start_y;
                n_goal_col    = i_item.end_x;
                n_goal_row    = i_item.end_y;
                n_err         = st_err;
                n_twice_dx    = st_tdx;
                n_twice_dy    = st_tdy;
                n_col_down    = st_col_down;
                n_row_down    = st_row_down;
                n_col_major   = st_col_major;
                n_color       = i_item.color;
                n_pixel.last  = st_col_major ? (i_item.start_x == i_item.end_x)
                                             : (i_item.start_y == i_item.end_y);
            end else if (r_busy) begin
                if (r_col_major) begin
                    n_cur_col = col_moved;
                    if (err_nonneg) begin
                        n_cur_row = row_moved;
                        n_err     = r_err - tdx_ext + tdy_ext;
                    end else begin
                        n_err     = r_err + tdy_ext;
                    end
                    n_pixel.last = col_moved == r_goal_col;
                end else begin
                    n_cur_row = row_moved;
                    if (err_nonneg) begin
                        n_cur_col = col_moved;
                        n_err     = r_err - tdy_ext + tdx_ext;
                    end else begin
                        n_err     = r_err + tdx_ext;
                    end
                    n_pixel.last = row_moved == r_goal_row;
                end
            end
            if (has_result) begin
                n_busy        = !n_pixel.last;
                n_pixel.x     = n_cur_col;
                n_pixel.y     = n_cur_row;
                n_pixel.color = n_color;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
        end
    end

    // Line state and result registers; only read while busy or valid.
    always_ff @(posedge i_clk) begin
        r_cur_col   <= n_cur_col;
        r_cur_row   <= n_cur_row;
        r_goal_col  <= n_goal_col;
        r_goal_row  <= n_goal_row;
        r_err       <= n_err;
        r_twice_dx  <= n_twice_dx;
        r_twice_dy  <= n_twice_dy;
        r_col_down  <= n_col_down;
        r_row_down  <= n_row_down;
        r_col_major <= n_col_major;
        r_color     <= n_color;
        r_pixel     <= n_pixel;
    end

    assign o_out_valid     = r_valid;
    assign o_pixel         = r_pixel;
    assign o_status.busy   = r_busy;
    assign o_status.accept = accept;

endmodule

`default_nettype wire

[design/lpg_addr.sv]
// Address stage: forms x + y * stride and holds the outgoing pixel word.
// Depends on lpg_pkg for the pixel type and field widths.
`default_nettype none

module lpg_addr (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [lpg_pkg::STRIDE_W-1:0]     i_stride,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  lpg_pkg::t_pixel            i_pixel,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [lpg_pkg::ADDR_W-1:0]       o_pixel_address,
    output logic [lpg_pkg::COLOR_W-1:0]      o_pixel_value,
    output logic                             o_last
);
    import lpg_pkg::*;

    logic r_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [ADDR_W-1:0]  r_addr;
    logic [COLOR_W-1:0] r_color;
    logic               r_last;

    logic [ADDR_W-1:0] y_ext;
    logic [ADDR_W-1:0] stride_ext;
    logic [ADDR_W-1:0] n_addr;
    logic              load;

    assign o_in_ready = !r_valid || i_out_ready;
    assign load       = i_in_valid && o_in_ready;

    // Row offset plus column, wrapping to the address width.
    assign y_ext      = ADDR_W'(i_pixel.y);
    assign stride_ext = ADDR_W'(i_stride);
    assign n_addr     = ADDR_W'(y_ext * stride_ext) + ADDR_W'(i_pixel.x);

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x     <= i_pixel.x;
            r_y     <= i_pixel.y;
            r_addr  <= n_addr;
            r_color <= i_pixel.color;
            r_last  <= i_pixel.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_pixel_x       = r_x;
    assign o_pixel_y       = r_y;
    assign o_pixel_address = r_addr;
    assign o_pixel_value   = r_color;
    assign o_last          = r_last;

endmodule

`default_nettype wire

[design/line_pixel_generator.sv]
// Top level of the line pixel generator: input register, stepper, address stage.
// Depends on lpg_pkg, lpg_stepper and lpg_addr.
`default_nettype none

// A start word (func = 0) carries two endpoints and a color and produces the
// first pixel of the line; each step word (func = 1) produces the next pixel,
// and the pixel at the end point comes out with last set. A step word while no
// line is active produces nothing, and a start word always abandons the line in
// progress. The block takes one word per clock and delivers one pixel per clock
// when the output side is ready; a pixel is presented once its word has passed
// three registers (input register, Bresenham error update, address multiply). The
// rate is set by the single error-term add and compare in the stepper. The stride
// register may only be written while no pixel is pending.

module line_pixel_generator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [lpg_pkg::STRIDE_W-1:0]     i_cfg_wdata,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_func,
    input  wire  [lpg_pkg::COORD_W-1:0]      i_start_x,
    input  wire  [lpg_pkg::COORD_W-1:0]      i_start_y,
    input  wire  [lpg_pkg::COORD_W-1:0]      i_end_x,
    input  wire  [lpg_pkg::COORD_W-1:0]      i_end_y,
    input  wire  [lpg_pkg::COLOR_W-1:0]      i_pixel_color,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_x,
    output logic [lpg_pkg::COORD_W-1:0]      o_pixel_y,
    output logic [lpg_pkg::ADDR_W-1:0]       o_pixel_address,
    output logic [lpg_pkg::COLOR_W-1:0]      o_pixel_value,
    output logic                             o_last
);
    import lpg_pkg::*;

    logic [STRIDE_W-1:0] r_line_stride;
    logic                r_s1_valid;
    t_item               r_s1_item;

    logic         step_ready;
    logic         step_valid;
    t_pixel       step_pixel;
    t_step_status step_status;
    logic         addr_ready;

    // Stride register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_stride <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            r_line_stride <= i_cfg_wdata;
        end
    end

    // Input register.
    assign o_in_ready = !r_s1_valid || step_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_item.func    <= t_func'(i_func);
            r_s1_item.start_x <= i_start_x;
            r_s1_item.start_y <= i_start_y;
            r_s1_item.end_x   <= i_end_x;
            r_s1_item.end_y   <= i_end_y;
            r_s1_item.color   <= i_pixel_color;
        end
    end

    // Bresenham stepper.
    lpg_stepper u_stepper (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_s1_valid),
        .o_in_ready  (step_ready),
        .i_item      (r_s1_item),
        .o_out_valid (step_valid),
        .i_out_ready (addr_ready),
        .o_pixel     (step_pixel),
        .o_status    (step_status)
    );

    // Address stage and output register.
    lpg_addr u_addr (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stride        (r_line_stride),
        .i_in_valid      (step_valid),
        .o_in_ready      (addr_ready),
        .i_pixel         (step_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last          (o_last)
    );

    // A step word taken with no active line produces no pixel.
    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_status.accept && !step_status.busy && r_s1_item.func == FUNC_STEP)
        |=> !step_valid)
        else $error("step word with no active line produced a pixel");

    // Every start word produces a pixel.
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_status.accept && r_s1_item.func == FUNC_START) |=> step_valid)
        else $error("start word produced no pixel");

    // The line ends exactly when its last pixel is produced.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_status.accept && (r_s1_item.func == FUNC_START || step_status.busy))
        |=> (step_pixel.last == !step_status.busy))
        else $error("busy flag disagrees with the last-pixel marker");

    // The address matches the coordinates and stride it was formed from.
    a_addr_formed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_valid && addr_ready) |=>
        (o_pixel_address == ADDR_W'(ADDR_W'($past(step_pixel.y))
            * ADDR_W'($past(r_line_stride)) + ADDR_W'($past(step_pixel.x)))))
        else $error("pixel address does not match its coordinates");

endmodule

`default_nettype wire

[tb/line_pixel_generator_tb.sv]
// Self-checking testbench for the line pixel generator: a directed word table,
// then random line sequences under several idle and stall profiles.
// Depends on lpg_pkg and the line_pixel_generator RTL.
`default_nettype none

module line_pixel_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    localparam int COORD_MAX     = COORD_SPAN - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;

    // One pixel as it should leave the block.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] value;
        logic               last;
    } t_out_pixel;

    // One row of the directed table.
    typedef struct {
        t_item      word;
        bit         typed;
        bit         fires;
        t_out_pixel want;
    } t_table_row;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [STRIDE_W-1:0] i_cfg_wdata   = '0;
    logic                i_in_valid    = 1'b0;
    logic                i_func        = 1'b0;
    logic [COORD_W-1:0]  i_start_x     = '0;
    logic [COORD_W-1:0]  i_start_y     = '0;
    logic [COORD_W-1:0]  i_end_x       = '0;
    logic [COORD_W-1:0]  i_end_y       = '0;
    logic [COLOR_W-1:0]  i_pixel_color = '0;
    logic                i_out_ready   = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [COORD_W-1:0]  o_pixel_x;
    logic [COORD_W-1:0]  o_pixel_y;
    logic [ADDR_W-1:0]   o_pixel_address;
    logic [COLOR_W-1:0]  o_pixel_value;
    logic                o_last;

    line_pixel_generator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_pixel_color   (i_pixel_color),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last          (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Rasterizer state mirrored by the predictor.
    logic [STRIDE_W-1:0] stride_reg = STRIDE_RESET;
    bit                  walking    = 1'b0;
    logic [COORD_W-1:0]  at_x       = '0;
    logic [COORD_W-1:0]  at_y       = '0;
    logic [COORD_W-1:0]  stop_x     = '0;
    logic [COORD_W-1:0]  stop_y     = '0;
    int                  err_acc    = 0;
    int                  ddx        = 0;
    int                  ddy        = 0;
    bit                  x_neg      = 1'b0;
    bit                  y_neg      = 1'b0;
    bit                  x_leads    = 1'b0;
    logic [COLOR_W-1:0]  ink        = '0;

    t_out_pixel pending_pixels[$];
    t_table_row word_table[$];
    int         mismatch_count = 0;
    int         sender_idle    = 0;
    int         recv_stall     = 0;
    logic       hold_ready     = 1'b0;
    int         quiet_cycles   = 0;
    t_out_pixel got;
    t_out_pixel want;

    function automatic t_out_pixel pix(int x, int y, int addr, int value, bit last);
        t_out_pixel p;
        p.x     = COORD_W'(x);
        p.y     = COORD_W'(y);
        p.addr  = ADDR_W'(addr);
        p.value = COLOR_W'(value);
        p.last  = last;
        return p;
    endfunction

    function automatic t_item start_word(int sx, int sy, int ex, int ey, int color);
        t_item w;
        w.func    = FUNC_START;
        w.start_x = COORD_W'(sx);
        w.start_y = COORD_W'(sy);
        w.end_x   = COORD_W'(ex);
        w.end_y   = COORD_W'(ey);
        w.color   = COLOR_W'(color);
        return w;
    endfunction

    // A step word carries random fields that the block must ignore.
    function automatic t_item step_word();
        t_item w;
        w.func    = FUNC_STEP;
        w.start_x = COORD_W'($urandom);
        w.start_y = COORD_W'($urandom);
        w.end_x   = COORD_W'($urandom);
        w.end_y   = COORD_W'($urandom);
        w.color   = COLOR_W'($urandom);
        return w;
    endfunction

    // Bresenham predictor: updates the mirrored state for one accepted word.
    function automatic void rasterize_word(input t_item w, output bit fired,
                                           output t_out_pixel px);
        int sx;
        int sy;
        int ex;
        int ey;
        bit done;
        sx = int'(w.start_x);
        sy = int'(w.start_y);
        ex = int'(w.end_x);
        ey = int'(w.end_y);
        px = '0;
        fired = 1'b0;
        if (w.func == FUNC_START) begin
            x_neg   = ex < sx;
            y_neg   = ey < sy;
            ddx     = (x_neg ? sx - ex : ex - sx) * 2;
            ddy     = (y_neg ? sy - ey : ey - sy) * 2;
            x_leads = ddx > ddy;
            err_acc = x_leads ? ddy - ddx / 2 : ddx - ddy / 2;
            at_x    = w.start_x;
            at_y    = w.start_y;
            stop_x  = w.end_x;
            stop_y  = w.end_y;
            ink     = w.color;
            done    = x_leads ? (sx == ex) : (sy == ey);
        end else if (!walking) begin
            return;
        end else if (x_leads) begin
            if (err_acc >= 0) begin
                at_y    = y_neg ? at_y - 1'b1 : at_y + 1'b1;
                err_acc = err_acc - ddx;
            end
            at_x    = x_neg ? at_x - 1'b1 : at_x + 1'b1;
            err_acc = err_acc + ddy;
            done    = at_x == stop_x;
        end else begin
            if (err_acc >= 0) begin
                at_x    = x_neg ? at_x - 1'b1 : at_x + 1'b1;
                err_acc = err_acc - ddy;
            end
            at_y    = y_neg ? at_y - 1'b1 : at_y + 1'b1;
            err_acc = err_acc + ddx;
            done    = at_y == stop_y;
        end
        walking  = !done;
        fired    = 1'b1;
        px.x     = at_x;
        px.y     = at_y;
        px.addr  = ADDR_W'(32'(at_x) + 32'(at_y) * 32'(stride_reg));
        px.value = ink;
        px.last  = done;
    endfunction

    // Random point within span of v, kept on the screen.
    function automatic int near(int v, int span);
        int lo;
        int hi;
        lo = (v - span < 0) ? 0 : v - span;
        hi = (v + span > COORD_MAX) ? COORD_MAX : v + span;
        return $urandom_range(hi, lo);
    endfunction

    // Offer one word and return once it has been accepted.
    task automatic offer(input t_item w);
        while ($urandom_range(0, 99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= w.func;
        i_start_x     <= w.start_x;
        i_start_y     <= w.start_y;
        i_end_x       <= w.end_x;
        i_end_y       <= w.end_y;
        i_pixel_color <= w.color;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Offer a word and queue the pixel that the predictor expects from it.
    task automatic send(input t_item w, output bit fired);
        t_out_pixel px;
        offer(w);
        rasterize_word(w, fired, px);
        if (fired) pending_pixels.push_back(px);
    endtask

    task automatic typed_row(input t_item w, input bit fires, input t_out_pixel p);
        t_table_row r;
        r.word  = w;
        r.typed = 1'b1;
        r.fires = fires;
        r.want  = p;
        word_table.push_back(r);
    endtask

    task automatic model_row(input t_item w);
        t_table_row r;
        r.word  = w;
        r.typed = 1'b0;
        r.fires = 1'b0;
        r.want  = '0;
        word_table.push_back(r);
    endtask

    // Drain the block, let it settle, then write the stride register.
    task automatic set_stride(input int value);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= STRIDE_W'(value);
        @(posedge i_clk);
        stride_reg = STRIDE_W'(value);
        i_cfg_we <= 1'b0;
    endtask

    // Random lines: mostly complete walks, some cut short by a new start,
    // and a few idle steps after a line has ended.
    task automatic run_lines(input int words);
        int made;
        int kind;
        int cut;
        int n;
        int sx;
        int sy;
        int ex;
        int ey;
        bit f;
        made = 0;
        while (made < words) begin
            sx   = $urandom_range(COORD_MAX, 0);
            sy   = $urandom_range(COORD_MAX, 0);
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                ex = near(sx, 24);
                ey = near(sy, 24);
            end else if (kind < 92) begin
                ex = near(sx, 96);
                ey = near(sy, 96);
            end else if (kind < 97) begin
                ex = $urandom_range(COORD_MAX, 0);
                ey = $urandom_range(COORD_MAX, 0);
            end else begin
                sx = $urandom_range(0, 1) * COORD_MAX;
                sy = $urandom_range(0, 1) * COORD_MAX;
                ex = $urandom_range(0, 1) * COORD_MAX;
                ey = $urandom_range(0, 1) * COORD_MAX;
            end
            send(start_word(sx, sy, ex, ey, $urandom), f);
            made += int'(f);
            cut = ($urandom_range(0, 99) < 80) ? COORD_SPAN : $urandom_range(0, 60);
            n = 0;
            while (walking && n < cut && made < words) begin
                send(step_word(), f);
                made += int'(f);
                n++;
            end
            if ($urandom_range(0, 99) < 8) begin
                repeat ($urandom_range(1, 2)) send(step_word(), f);
            end
        end
    endtask

    // Output side: random stalls, a long hold-off when asked, and the check.
    always @(posedge i_clk) begin
        i_out_ready <= !hold_ready && ($urandom_range(0, 99) >= recv_stall);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = pix(o_pixel_x, o_pixel_y, o_pixel_address, o_pixel_value, o_last);
            if (pending_pixels.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected pixel x=%0d y=%0d addr=%0d value=%h last=%b",
                             got.x, got.y, got.addr, got.value, got.last);
                end
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got != want) begin
                    if (mismatch_count < 10) begin
                        $display("pixel mismatch: want x=%0d y=%0d addr=%0d value=%h last=%b",
                                 want.x, want.y, want.addr, want.value, want.last);
                        $display("                 got x=%0d y=%0d addr=%0d value=%h last=%b",
                                 got.x, got.y, got.addr, got.value, got.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_out_pixel px;
        bit         f;

        // Directed table, all at the reset stride.
        typed_row(step_word(), 1'b0, '0);
        typed_row(start_word(0, 0, 0, 0, 16'hFFFF), 1'b1, pix(0, 0, 0, 16'hFFFF, 1'b1));
        typed_row(step_word(), 1'b0, '0);
        typed_row(start_word(511, 511, 511, 511, 16'h0000), 1'b1,
                  pix(511, 511, 262143, 16'h0000, 1'b1));
        typed_row(start_word(0, 0, 3, 0, 16'h1234), 1'b1, pix(0, 0, 0, 16'h1234, 1'b0));
        typed_row(step_word(), 1'b1, pix(1, 0, 1, 16'h1234, 1'b0));
        typed_row(step_word(), 1'b1, pix(2, 0, 2, 16'h1234, 1'b0));
        typed_row(step_word(), 1'b1, pix(3, 0, 3, 16'h1234, 1'b1));
        typed_row(step_word(), 1'b0, '0);
        typed_row(start_word(5, 511, 5, 509, 16'h00FF), 1'b1,
                  pix(5, 511, 261637, 16'h00FF, 1'b0));
        model_row(step_word());
        model_row(step_word());
        model_row(start_word(511, 0, 508, 2, 16'hFF00));
        repeat (3) model_row(step_word());
        // A new start in the middle of a line abandons it.
        model_row(start_word(10, 10, 20, 15, 16'hA5A5));
        model_row(step_word());
        model_row(start_word(0, 511, 511, 0, 16'h5A5A));
        repeat (2) model_row(step_word());
        model_row(start_word(0, 0, 511, 1, 16'h8001));
        model_row(step_word());
        model_row(start_word(1, 2, 2, 4, 16'h0001));
        repeat (2) model_row(step_word());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (word_table[i]) begin
            offer(word_table[i].word);
            rasterize_word(word_table[i].word, f, px);
            if (word_table[i].typed) begin
                if (word_table[i].fires) pending_pixels.push_back(word_table[i].want);
            end else if (f) begin
                pending_pixels.push_back(px);
            end
        end

        // No idling, stride of one, and one long output hold-off.
        set_stride(1);
        sender_idle = 0;
        recv_stall  = 0;
        fork
            begin
                hold_ready <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ready <= 1'b0;
            end
        join_none
        run_lines(215);

        // Largest stride, sender mostly idle.
        set_stride(1023);
        sender_idle = 75;
        recv_stall  = 0;
        run_lines(215);

        // Zero stride, receiver mostly stalled.
        set_stride(0);
        sender_idle = 0;
        recv_stall  = 75;
        run_lines(215);

        // Random legal stride, both sides idling now and then.
        set_stride($urandom_range(512, 1));
        sender_idle = 20;
        recv_stall  = 20;
        run_lines(215);

        // Back to the full-row stride with no idling.
        set_stride(512);
        sender_idle = 0;
        recv_stall  = 0;
        run_lines(215);

        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
